### rtl/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg - shared definitions for the infix to postfix converter
// Character codes, default stack depth and the operator precedence function.
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam int STACK_DEPTH_DEF = 16;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;

    typedef logic [1:0] t_prec;

    // '(' binds loosest so it is never popped by an operator.
    function automatic t_prec prec(input logic [7:0] c);
        t_prec p;
        if (c == CH_LPAREN) begin
            p = 2'd0;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
            p = 2'd1;
        end else if (c == CH_STAR || c == CH_SLASH || c == CH_PCT) begin
            p = 2'd2;
        end else begin
            p = 2'd3;
        end
        return p;
    endfunction

endpackage

### rtl/itp_in_if.sv
// ----------------------------------------------------------------------------
// itp_in_if - infix character channel
// Valid/ready channel carrying one input character and the finish marker.
// ----------------------------------------------------------------------------
interface itp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       finish;

    modport source (output valid, output in_char, output finish, input ready);
    modport sink   (input valid, input in_char, input finish, output ready);
endinterface

### rtl/itp_out_if.sv
// ----------------------------------------------------------------------------
// itp_out_if - postfix character channel
// Valid/ready channel carrying one output character, last and error flags.
// ----------------------------------------------------------------------------
interface itp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last;
    logic       error;

    modport source (output valid, output out_char, output last, output error,
                    input ready);
    modport sink   (input valid, input out_char, input last, input error,
                    output ready);
endinterface

### rtl/itp_stack.sv
// ----------------------------------------------------------------------------
// itp_stack - operator stack storage
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module itp_stack #(
    parameter int  DEPTH = itp_pkg::STACK_DEPTH_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/infix_to_postfix_converter_core.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core - shunting-yard infix to postfix converter
// Takes an infix expression one character per beat and emits postfix text.
// ----------------------------------------------------------------------------
//
//  Port    Dir  Beat contents                    Notes
//  i_in    in   in_char[7:0], finish             finish ends the expression
//  o_out   out  out_char[7:0], last, error       last marks the NUL terminator
//
//  Steps: space, NUL or '(' accept only; letter or digit: accept, separator
//  slot, char. An operator, ')' or finish: accept, issue and check per stack
//  read, separator slot and char per popped operator, a final step if the stack
//  runs empty, terminator on finish; the registered stack read paces the pop loop.
//  Reset: synchronous, active low; clears state, stack count and flags only.
//  Stalls: sequencer holds while the one-beat output register is full, unread.
//
module infix_to_postfix_converter_core #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    itp_in_if.sink    i_in,
    itp_out_if.source o_out
);
    import itp_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,     // issue read of stack top
        S_CHK,    // top available: decide pop / stop
        S_SEP,    // owed separator
        S_CH,     // item character
        S_TERM    // NUL terminator
    } t_state;

    typedef enum logic [1:0] {
        K_FIN,
        K_CLOSE,
        K_OP
    } t_kind;

    t_state       r_state, n_state;
    t_state       r_ret,   n_ret;
    t_kind        r_kind,  n_kind;
    logic [CW-1:0] r_count, n_count;
    logic         r_sp,    n_sp;
    logic         r_prev,  n_prev;
    logic         r_err,   n_err;
    logic [7:0]   r_c,     n_c;
    logic [7:0]   r_ch,    n_ch;
    logic         r_ov,    n_ov;
    logic [7:0]   r_oc,    n_oc;
    logic         r_ol,    n_ol;
    logic         r_oe,    n_oe;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [7:0]    top;
    logic [CW-1:0] cnt_m1;
    logic          can_load;
    logic          in_acc;
    logic          not_full;

    itp_stack #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (cnt_m1[AW-1:0]),
        .o_rdata (top)
    );

    assign i_in.ready     = (r_state == S_IDLE);
    assign in_acc         = i_in.valid && i_in.ready;
    assign can_load       = !r_ov || o_out.ready;
    assign cnt_m1         = r_count - CW'(1);
    assign not_full       = (r_count < CW'(STACK_DEPTH));
    assign mem_waddr      = r_count[AW-1:0];

    assign o_out.valid    = r_ov;
    assign o_out.out_char = r_oc;
    assign o_out.last     = r_ol;
    assign o_out.error    = r_oe;

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_kind    = r_kind;
        n_count   = r_count;
        n_sp      = r_sp;
        n_prev    = r_prev;
        n_err     = r_err;
        n_c       = r_c;
        n_ch      = r_ch;
        n_ov      = r_ov && !o_out.ready;
        n_oc      = r_oc;
        n_ol      = r_ol;
        n_oe      = r_oe;
        mem_we    = 1'b0;
        mem_wdata = r_c;
        mem_re    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_c = i_in.in_char;
                    if (i_in.finish) begin
                        n_kind  = K_FIN;
                        n_state = S_RD;
                    end else if (i_in.in_char == CH_SPACE || i_in.in_char == CH_NUL) begin
                        n_prev = 1'b0;
                    end else if (i_in.in_char inside {[CH_0:CH_9]}) begin
                        // digit right after a letter or digit continues the run: no separator
                        if (r_prev) begin
                            n_sp = 1'b0;
                        end
                        n_ch    = i_in.in_char;
                        n_ret   = S_IDLE;
                        n_prev  = 1'b1;
                        n_state = S_SEP;
                    end else if (i_in.in_char inside {[CH_UA:CH_UZ], [CH_LA:CH_LZ]}) begin
                        n_ch    = i_in.in_char;
                        n_ret   = S_IDLE;
                        n_prev  = 1'b1;
                        n_state = S_SEP;
                    end else if (i_in.in_char == CH_LPAREN) begin
                        n_prev    = 1'b0;
                        mem_wdata = i_in.in_char;
                        if (not_full) begin
                            mem_we  = 1'b1;
                            n_count = r_count + CW'(1);
                        end else begin
                            n_err = 1'b1;
                        end
                    end else if (i_in.in_char == CH_RPAREN) begin
                        n_prev  = 1'b0;
                        n_kind  = K_CLOSE;
                        n_state = S_RD;
                    end else begin
                        n_prev  = 1'b0;
                        n_kind  = K_OP;
                        n_state = S_RD;
                    end
                end
            end

            S_RD: begin
                if (r_count != '0) begin
                    mem_re  = 1'b1;
                    n_state = S_CHK;
                end else begin
                    case (r_kind)
                        K_FIN: begin
                            n_state = S_TERM;
                        end
                        K_CLOSE: begin
                            // ran out of stack without a '('
                            n_err   = 1'b1;
                            n_state = S_IDLE;
                        end
                        default: begin
                            mem_we  = 1'b1;
                            n_count = r_count + CW'(1);
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_CHK: begin
                case (r_kind)
                    K_FIN: begin
                        n_count = cnt_m1;
                        n_ch    = top;
                        n_ret   = S_RD;
                        n_state = S_SEP;
                    end
                    K_CLOSE: begin
                        n_count = cnt_m1;
                        if (top == CH_LPAREN) begin
                            n_state = S_IDLE;
                        end else begin
                            n_ch    = top;
                            n_ret   = S_RD;
                            n_state = S_SEP;
                        end
                    end
                    default: begin
                        if (prec(r_c) <= prec(top)) begin
                            n_count = cnt_m1;
                            n_ch    = top;
                            n_ret   = S_RD;
                            n_state = S_SEP;
                        end else begin
                            if (not_full) begin
                                mem_we  = 1'b1;
                                n_count = r_count + CW'(1);
                            end else begin
                                n_err = 1'b1;
                            end
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end

            S_SEP: begin
                if (!r_sp) begin
                    n_state = S_CH;
                end else if (can_load) begin
                    n_ov    = 1'b1;
                    n_oc    = CH_SPACE;
                    n_ol    = 1'b0;
                    n_oe    = r_err;
                    n_sp    = 1'b0;
                    n_state = S_CH;
                end
            end

            S_CH: begin
                if (can_load) begin
                    n_ov    = 1'b1;
                    n_oc    = r_ch;
                    n_ol    = 1'b0;
                    n_oe    = r_err;
                    n_sp    = 1'b1;
                    n_state = r_ret;
                end
            end

            S_TERM: begin
                if (can_load) begin
                    n_ov    = 1'b1;
                    n_oc    = CH_NUL;
                    n_ol    = 1'b1;
                    n_oe    = r_err;
                    // expression done: back to a clean slate
                    n_count = '0;
                    n_sp    = 1'b0;
                    n_prev  = 1'b0;
                    n_err   = 1'b0;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_sp    <= 1'b0;
            r_prev  <= 1'b0;
            r_err   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_sp    <= n_sp;
            r_prev  <= n_prev;
            r_err   <= n_err;
            r_ov    <= n_ov;
        end
        r_ret  <= n_ret;
        r_kind <= n_kind;
        r_c    <= n_c;
        r_ch   <= n_ch;
        r_oc   <= n_oc;
        r_ol   <= n_ol;
        r_oe   <= n_oe;
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // stack fill never passes its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count above depth");

    // stack top is only examined right after its read was issued
    a_chk_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) |-> ($past(r_state) == S_RD && $past(mem_re)))
        else $error("stack top used without a read");

    // terminator leaves the converter with an empty stack and clear error
    a_term_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TERM && can_load) |=>
            (r_count == '0 && !r_err && r_ov && r_ol))
        else $error("terminator did not clear state");

    // no new beat loaded over a stalled one
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_out.ready) |=> (r_ov && $stable(r_oc) && $stable(r_ol)))
        else $error("output beat overwritten while stalled");

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - testbench for the infix to postfix converter core
// Feeds directed and random infix text through the input channel, predicts
// the postfix beats in step with each accepted input beat and checks every
// output beat field by field, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
    import itp_pkg::*;

    localparam int STACK_MAX  = STACK_DEPTH_DEF;
    localparam int LONG_HOLD  = 300;
    localparam int RAND_BEATS = 380;
    localparam int CALM_AT    = 330;

    typedef struct {
        logic [7:0] ch;
        logic       fin;
        bit         calm;
    } t_infix_beat;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       err;
    } t_postfix_beat;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    itp_in_if  in_ch ();
    itp_out_if out_ch ();

    infix_to_postfix_converter_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_infix_beat   infix_q[$];
    t_postfix_beat postfix_q[$];

    // converter state as the predictor sees it
    logic [7:0] ops[STACK_MAX];
    int         ops_depth  = 0;
    bit         sep_owed   = 1'b0;
    bit         in_alnum   = 1'b0;
    bit         err_sticky = 1'b0;

    int          fail_cnt  = 0;
    int          n_sent    = 0;
    int          hold_req  = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          stall_left = 0;
    int          send_gap  = 0;
    bit          calm_now  = 1'b0;
    bit          quiet     = 1'b0;
    t_infix_beat nxt;

    function automatic int op_rank(input logic [7:0] c);
        if (c == CH_LPAREN) return 0;
        if (c == CH_PLUS || c == CH_MINUS) return 1;
        if (c == CH_STAR || c == CH_SLASH || c == CH_PCT) return 2;
        return 3;
    endfunction

    task automatic put_char(input logic [7:0] c, input logic lst);
        t_postfix_beat r;
        r.ch   = c;
        r.last = lst;
        r.err  = err_sticky;
        postfix_q.push_back(r);
    endtask

    // separator is owed lazily and only paid before the next real char
    task automatic put_item(input logic [7:0] c);
        if (sep_owed) begin
            put_char(CH_SPACE, 1'b0);
        end
        put_char(c, 1'b0);
        sep_owed = 1'b1;
    endtask

    task automatic push_op(input logic [7:0] c);
        if (ops_depth < STACK_MAX) begin
            ops[ops_depth] = c;
            ops_depth++;
        end else begin
            err_sticky = 1'b1;
        end
    endtask

    task automatic convert_beat(input logic [7:0] c, input logic fin);
        logic [7:0] top;
        bit         matched;
        if (fin) begin
            while (ops_depth > 0) begin
                ops_depth--;
                put_item(ops[ops_depth]);
            end
            sep_owed = 1'b0;
            put_char(CH_NUL, 1'b1);
            ops_depth  = 0;
            in_alnum   = 1'b0;
            err_sticky = 1'b0;
        end else if (c == CH_SPACE || c == CH_NUL) begin
            in_alnum = 1'b0;
        end else if (c >= CH_0 && c <= CH_9) begin
            // digit right after a letter or digit continues the run
            if (in_alnum) begin
                sep_owed = 1'b0;
            end
            put_item(c);
            in_alnum = 1'b1;
        end else if ((c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ)) begin
            put_item(c);
            in_alnum = 1'b1;
        end else begin
            in_alnum = 1'b0;
            if (c == CH_LPAREN) begin
                push_op(c);
            end else if (c == CH_RPAREN) begin
                matched = 1'b0;
                while (ops_depth > 0 && !matched) begin
                    ops_depth--;
                    top = ops[ops_depth];
                    if (top == CH_LPAREN) begin
                        matched = 1'b1;
                    end else begin
                        put_item(top);
                    end
                end
                if (!matched) begin
                    err_sticky = 1'b1;
                end
            end else begin
                while (ops_depth > 0 && op_rank(c) <= op_rank(ops[ops_depth - 1])) begin
                    ops_depth--;
                    put_item(ops[ops_depth]);
                end
                push_op(c);
            end
        end
    endtask

    task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
        fail_cnt++;
        if (fail_cnt <= 50) begin
            $display("%0t mismatch %s: got %02h want %02h", $realtime, what, got, want);
        end
    endtask

    task automatic check_beat();
        t_postfix_beat w;
        if (postfix_q.size() == 0) begin
            report("unexpected beat", out_ch.out_char, 8'h00);
        end else begin
            w = postfix_q.pop_front();
            if (out_ch.out_char !== w.ch) report("out_char", out_ch.out_char, w.ch);
            if (out_ch.last !== w.last) report("last", 8'(out_ch.last), 8'(w.last));
            if (out_ch.error !== w.err) report("error", 8'(out_ch.error), 8'(w.err));
        end
    endtask

    // sender: one beat offered at a time, random idle bursts until the calm tail
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid   <= 1'b0;
            in_ch.in_char <= 8'h00;
            in_ch.finish  <= 1'b0;
            send_gap      <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                convert_beat(in_ch.in_char, in_ch.finish);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    in_ch.valid <= 1'b0;
                    send_gap    <= send_gap - 1;
                end else if (infix_q.size() == 0) begin
                    in_ch.valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 7) == 0) begin
                    in_ch.valid <= 1'b0;
                    send_gap    <= $urandom_range(0, 8);
                end else begin
                    nxt = infix_q.pop_front();
                    in_ch.valid   <= 1'b1;
                    in_ch.in_char <= nxt.ch;
                    in_ch.finish  <= nxt.fin;
                    if (nxt.calm) begin
                        quiet <= 1'b1;
                    end
                end
            end
        end
    end

    // receiver: checks each taken beat; long hold on request, else short stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left   <= 0;
            hold_left    <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                check_beat();
            end
            if (hold_seen != hold_req) begin
                hold_seen    <= hold_req;
                hold_left    <= LONG_HOLD;
                out_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left    <= hold_left - 1;
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left   <= stall_left - 1;
                out_ch.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_left   <= $urandom_range(0, 8);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send(input logic [7:0] c, input logic fin);
        t_infix_beat b;
        b.ch   = c;
        b.fin  = fin;
        b.calm = calm_now;
        infix_q.push_back(b);
        n_sent++;
    endtask

    task automatic send_text(input string s);
        foreach (s[k]) begin
            send(s[k], 1'b0);
        end
    endtask

    task automatic send_end();
        send(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic maybe_space();
        case ($urandom_range(0, 7))
            0, 1: send(CH_SPACE, 1'b0);
            2:    send(CH_NUL, 1'b0);
            default: ;
        endcase
    endtask

    task automatic send_operand();
        case ($urandom_range(0, 3))
            0: send(8'(CH_LA + $urandom_range(0, 25)), 1'b0);
            1: send(8'(CH_UA + $urandom_range(0, 25)), 1'b0);
            2: repeat ($urandom_range(1, 3)) send(8'(CH_0 + $urandom_range(0, 9)), 1'b0);
            default: begin
                send(8'(CH_LA + $urandom_range(0, 25)), 1'b0);
                repeat ($urandom_range(1, 2)) send(8'(CH_0 + $urandom_range(0, 9)), 1'b0);
            end
        endcase
    endtask

    task automatic send_op();
        case ($urandom_range(0, 11))
            0, 1: send(CH_PLUS, 1'b0);
            2, 3: send(CH_MINUS, 1'b0);
            4, 5: send(CH_STAR, 1'b0);
            6:    send(CH_SLASH, 1'b0);
            7:    send(CH_PCT, 1'b0);
            8:    send("^", 1'b0);
            9:    send("&", 1'b0);
            10:   send("<", 1'b0);
            default: send(8'($urandom_range(128, 255)), 1'b0);
        endcase
    endtask

    task automatic send_term(input int lvl);
        if (lvl < 3 && $urandom_range(0, 3) == 0) begin
            send(CH_LPAREN, 1'b0);
            maybe_space();
            send_expr(lvl + 1);
            maybe_space();
            send(CH_RPAREN, 1'b0);
        end else begin
            send_operand();
        end
    endtask

    task automatic send_expr(input int lvl);
        send_term(lvl);
        repeat ($urandom_range(0, 3)) begin
            maybe_space();
            send_op();
            maybe_space();
            send_term(lvl);
        end
    endtask

    task automatic wait_drained();
        while (infix_q.size() != 0 || in_ch.valid || postfix_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty expression, all operators with nesting and runs,
        // then unmatched close, byte extremes and a NUL splitting a run
        send(8'hFF, 1'b1);
        send_text("a9+(Z-0)*1 2/z%A");
        send(8'h00, 1'b1);
        send(CH_RPAREN, 1'b0);
        send(8'hFF, 1'b0);
        send("7", 1'b0);
        send(CH_NUL, 1'b0);
        send("8", 1'b0);
        send(8'h00, 1'b1);

        // sender pauses here until every postfix beat is back
        wait_drained();

        // receiver holds off while the random stream starts
        hold_req++;
        while (n_sent < RAND_BEATS) begin
            if (n_sent > CALM_AT) begin
                calm_now = 1'b1;
            end
            case ($urandom_range(0, 9))
                0: begin
                    repeat ($urandom_range(1, 6)) begin
                        send(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
                    end
                end
                1: begin
                    // nesting that may be deep enough to overflow the stack
                    repeat ($urandom_range(14, 19)) send(CH_LPAREN, 1'b0);
                    send_operand();
                    repeat ($urandom_range(0, 3)) send(CH_RPAREN, 1'b0);
                    send_end();
                end
                2: begin
                    send_expr(0);
                    send(CH_RPAREN, 1'b0);
                    send_op();
                    send_expr(0);
                    if ($urandom_range(0, 1)) send(CH_LPAREN, 1'b0);
                    send_end();
                end
                default: begin
                    maybe_space();
                    send_expr(0);
                    maybe_space();
                    send_end();
                end
            endcase
        end
        if (infix_q[infix_q.size() - 1].fin !== 1'b1) begin
            send_end();
        end

        wait_drained();
        repeat (60) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
